// File: design/tme_pkg.sv
// Package for the tape machine executor: operation codes and the
// sequencer state type. No dependencies.
package tme_pkg;
	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SET = 4'd1, OP_LEND = 4'd2, OP_LSTART = 4'd3,
		OP_NOP = 4'd4, OP_ADDWZ = 4'd5, OP_ZFIND = 4'd6, OP_MFIND = 4'd7,
		OP_CALC = 4'd8, OP_CALC2 = 4'd9, OP_CALC3 = 4'd10, OP_COPY = 4'd11,
		OP_ACCUM = 4'd12, OP_INPUT = 4'd13, OP_PRINT = 4'd14, OP_STOP = 4'd15
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RDB, ST_RDC, ST_RDP, ST_MUL, ST_WR,
		ST_WRD, ST_WRB, ST_WSRC, ST_WINC, ST_DONE
	} state_t;
endpackage

// File: design/tme_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module tme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: design/tape_machine_executor.sv
// Tape machine executor top level. Uses tme_pkg and tme_ram.
// Holds the sequencer that reads, modifies and writes back the tape.
//
// The block runs one decoded instruction per word on a tape of TAPE_CELLS
// cells held in a single-port RAM. After the accepting edge each word passes
// through these states before DONE raises out_valid:
//   - nop, stop, and any word after stop: straight to DONE.
//   - set and input: WR.
//   - loop_start, loop_end and print: RDP.
//   - add: RDP, WR.
//   - copy and accum: RDB, RDP, WR.
//   - calc2 and calc3: RDB, RDP, MUL, WR.
//   - calc: RDB, RDC, RDP, MUL, WR.
// A walk runs RDP and WR, then repeats a step while the cell is nonzero:
// RDP, WR for zfind; RDB, WRB, RDP, WR for addwz; WRD, WSRC, WINC, RDP, WR
// for mfind. A walk stops after TAPE_CELLS steps and raises walk_overflow.
// A result is held in an output register until it is taken. The next word
// is accepted in the cycle after that. After reset the block sweeps the tape
// to zero, one cell per cycle, and accepts no word during that time. Once
// stop has run, every word returns halted only.
module tape_machine_executor
	import tme_pkg::*;
#(
	parameter int TAPE_CELLS = 65536,
	parameter int CELL_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  operation,
	input  logic signed [15:0] pointer_move,
	input  logic signed [15:0] value_a,
	input  logic signed [15:0] offset_b,
	input  logic signed [15:0] value_b,
	input  logic signed [15:0] offset_c,
	input  logic signed [15:0] value_c,
	input  logic [7:0]  input_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        branch_taken,
	output logic        print_valid,
	output logic [7:0]  print_byte,
	output logic        halted,
	output logic        walk_overflow
);
	localparam int AW = $clog2(TAPE_CELLS);
	localparam int SW = AW + 1;
	localparam int CB = CELL_BITS;

	state_t state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [SW-1:0] steps_q, steps_d;
	logic stopped_q, stopped_d;
	logic [3:0] op_q;
	logic signed [15:0] va_q, ob_q, vb_q, oc_q, vc_q;
	logic [7:0] inb_q;
	logic [CB-1:0] b_q, c_q, acc_q, m1_q, m2_q;
	logic [CB-1:0] b_d, c_d, acc_d;
	logic o_taken_q, o_pv_q, o_ovf_q, o_halt_q, ovalid_q;
	logic [7:0] o_pb_q;
	logic o_taken_d, o_pv_d, o_ovf_d, o_halt_d, ovalid_d;
	logic [7:0] o_pb_d;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [CB-1:0] ram_wdata, ram_rdata;

	tme_ram #(.WIDTH(CB), .DEPTH(TAPE_CELLS)) u_tape (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Pointer arithmetic wraps modulo the tape, a power of two.
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
	                                       input logic signed [15:0] off);
		logic signed [31:0] ext;
		begin
			ext = 32'(off);
			wrap = base + ext[AW-1:0];
		end
	endfunction

	function automatic logic [CB-1:0] cval(input logic signed [15:0] v);
		logic signed [32:0] ext;
		begin
			ext = 33'(v);
			cval = ext[CB-1:0];
		end
	endfunction

	wire accept_in = in_valid && !in_stall;
	wire accept_out = ovalid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	wire cell_nz = (ram_rdata != '0);
	wire walk_lim = (steps_q == SW'(TAPE_CELLS));
	wire [AW-1:0] ptr_in = wrap(ptr_q, pointer_move);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (ptr_q == AW'(TAPE_CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept_in && !stopped_q) begin
					case (operation)
						OP_CALC, OP_CALC2, OP_CALC3, OP_COPY,
						OP_ACCUM: state_d = ST_RDB;
						OP_ADDWZ, OP_ZFIND, OP_MFIND,
						OP_ADD, OP_LEND, OP_LSTART,
						OP_PRINT: state_d = ST_RDP;
						OP_SET, OP_INPUT: state_d = ST_WR;
						default: state_d = ST_DONE;
					endcase
				end else if (accept_in) begin
					state_d = ST_DONE;
				end
			end
			ST_RDB: state_d = (op_q == OP_CALC) ? ST_RDC : ST_RDP;
			ST_RDC: state_d = ST_RDP;
			ST_RDP: begin
				case (op_q)
					OP_CALC, OP_CALC2, OP_CALC3: state_d = ST_MUL;
					OP_ADDWZ, OP_ZFIND, OP_MFIND: state_d = ST_WR;
					OP_LEND, OP_LSTART, OP_PRINT: state_d = ST_DONE;
					default: state_d = ST_WR;
				endcase
			end
			ST_MUL: state_d = ST_WR;
			ST_WR: begin
				// For walks this state tests the cell under the pointer.
				case (op_q)
					OP_ADDWZ: state_d = (cell_nz && !walk_lim) ? ST_RDB : ST_DONE;
					OP_ZFIND: state_d = (cell_nz && !walk_lim) ? ST_RDP : ST_DONE;
					OP_MFIND: state_d = (cell_nz && !walk_lim) ? ST_WRD : ST_DONE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_WRD: state_d = ST_WSRC;
			ST_WSRC: state_d = ST_WINC;
			ST_WINC: state_d = ST_RDP;
			ST_WRB: state_d = ST_RDP;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		// addwz: RDB read target, then WRB writes it.
		if (state_q == ST_RDB && op_q == OP_ADDWZ) state_d = ST_WRB;
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = ptr_q;
		ram_wdata = '0;
		ptr_d = ptr_q;
		steps_d = steps_q;
		stopped_d = stopped_q;
		b_d = b_q;
		c_d = c_q;
		acc_d = acc_q;
		o_taken_d = o_taken_q;
		o_pv_d = o_pv_q;
		o_pb_d = o_pb_q;
		o_ovf_d = o_ovf_q;
		o_halt_d = o_halt_q;
		ovalid_d = ovalid_q && !accept_out;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ptr_d = ptr_q + 1'b1;
			end
			ST_IDLE: begin
				ram_addr = wrap(ptr_in, offset_b);
				steps_d = '0;
				if (accept_in && !stopped_q) begin
					ptr_d = ptr_in;
					if (!(operation inside {OP_CALC, OP_CALC2, OP_CALC3, OP_COPY,
					    OP_ACCUM})) ram_addr = ptr_in;
				end
			end
			ST_RDB: begin
				b_d = ram_rdata;
				ram_addr = (op_q == OP_ADDWZ) ? wrap(ptr_q, ob_q) : wrap(ptr_q, oc_q);
			end
			ST_RDC: begin
				c_d = ram_rdata;
			end
			ST_RDP: ;
			ST_MUL: begin
				acc_d = ram_rdata;
			end
			ST_WR: begin
				ram_we = 1'b1;
				case (op_q)
					OP_ADD: ram_wdata = ram_rdata + cval(va_q);
					OP_SET: ram_wdata = cval(va_q);
					OP_INPUT: ram_wdata = CB'(inb_q);
					OP_COPY: ram_wdata = b_q;
					OP_ACCUM: ram_wdata = ram_rdata + b_q;
					OP_CALC: ram_wdata = cval(va_q) + m1_q + m2_q;
					OP_CALC2: ram_wdata = cval(va_q) + m1_q;
					OP_CALC3: ram_wdata = acc_q + m1_q;
					default: begin
						ram_we = 1'b0;
						o_ovf_d = cell_nz;
						if (cell_nz && !walk_lim) begin
							steps_d = steps_q + 1'b1;
							if (op_q == OP_ZFIND) ptr_d = wrap(ptr_q, ob_q);
						end
					end
				endcase
			end
			ST_WRB: begin
				ram_addr = wrap(ptr_q, ob_q);
				ram_we = 1'b1;
				ram_wdata = ram_rdata + cval(vb_q);
				ptr_d = wrap(ptr_q, oc_q);
			end
			ST_WRD: begin
				ram_we = 1'b1;
				acc_d = ram_rdata;
				ram_addr = ptr_q;
				ram_wdata = ram_rdata - 1'b1;
				ptr_d = wrap(ptr_q, ob_q);
			end
			ST_WSRC: begin
				ram_addr = ptr_q;
			end
			ST_WINC: begin
				ram_we = 1'b1;
				ram_wdata = ram_rdata + 1'b1;
			end
			ST_DONE: begin
				ovalid_d = 1'b1;
			end
			default: ;
		endcase
		// Result fields are set up when the word is accepted and finished
		// as the operation runs.
		if (state_q == ST_IDLE && accept_in) begin
			o_taken_d = 1'b0;
			o_pv_d = 1'b0;
			o_pb_d = '0;
			o_ovf_d = 1'b0;
			if (!stopped_q && operation == OP_STOP) stopped_d = 1'b1;
			o_halt_d = stopped_q || (operation == OP_STOP);
			if (!stopped_q && operation == OP_PRINT && value_a != -16'sd1) begin
				o_pv_d = 1'b1;
				o_pb_d = value_a[7:0];
			end
		end
		if (state_q == ST_RDP) begin
			if (op_q == OP_LEND) o_taken_d = cell_nz;
			if (op_q == OP_LSTART) o_taken_d = !cell_nz;
			if (op_q == OP_PRINT) begin
				o_pv_d = 1'b1;
				if (va_q == -16'sd1) o_pb_d = ram_rdata[7:0];
			end
		end
	end

	// After a walk step the walk goes back through RDP, so the pointer cell is read again and tested in WR.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept_in) begin
			op_q <= operation;
			va_q <= value_a;
			ob_q <= offset_b;
			vb_q <= value_b;
			oc_q <= offset_c;
			vc_q <= value_c;
			inb_q <= input_byte;
		end
		b_q <= b_d;
		c_q <= c_d;
		acc_q <= acc_d;
		if (state_q == ST_RDP) begin
			m1_q <= CB'(b_q * cval(vb_q));
			m2_q <= CB'(((op_q == OP_CALC) ? c_q : '0) * cval(vc_q));
		end
		o_taken_q <= o_taken_d;
		o_pv_q <= o_pv_d;
		o_pb_q <= o_pb_d;
		o_ovf_q <= o_ovf_d;
		o_halt_q <= o_halt_d;
	end

	// For the calc family the first source is read when the word is accepted
	// and lands in RDB (b). For calc the second source is read in RDB and
	// lands in RDC (c). The products are registered in m1/m2 in RDP. For
	// calc3 the pointer cell, read in RDP, lands in acc in MUL.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q <= '0;
			steps_q <= '0;
			stopped_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q <= ptr_d;
			steps_q <= steps_d;
			stopped_q <= stopped_d;
			ovalid_q <= ovalid_d;
		end
	end

	assign out_valid = ovalid_q;
	assign branch_taken = o_taken_q;
	assign print_valid = o_pv_q;
	assign print_byte = o_pb_q;
	assign halted = o_halt_q;
	assign walk_overflow = o_ovf_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("word taken while busy");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= SW'(TAPE_CELLS)) else $error("walk step count past limit");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(stopped_q) |-> stopped_q) else $error("stop flag cleared");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid) else $error("result lost");
endmodule

// File: tb/sv/tb_tape_machine_executor.sv
// Self-checking testbench for tape_machine_executor: directed table, random words, then stop.
// Depends on tme_pkg (op_t) and the tape_machine_executor RTL, which uses tme_ram.
module tb_tape_machine_executor;
	import tme_pkg::*;

	localparam int TAPE_CELLS = 65536;
	localparam int RAND_WORDS = 1000;
	localparam int WALK_CAP = 64;

	typedef struct {
		op_t op;
		logic signed [15:0] mv, va, ob, vb, oc, vc;
		logic [7:0] ib;
	} word_t;

	typedef struct {
		bit taken, pv;
		logic [7:0] pb;
		bit halt, ovf;
	} outcome_t;

	typedef struct {
		word_t w;
		bit typed;
		outcome_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] operation = '0;
	logic signed [15:0] pointer_move = '0, value_a = '0, offset_b = '0;
	logic signed [15:0] value_b = '0, offset_c = '0, value_c = '0;
	logic [7:0] input_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic branch_taken, print_valid, halted, walk_overflow;
	logic [7:0] print_byte;

	// Shadow copy of the machine: tape, cell pointer and the stop flag.
	logic [7:0] tape_mem [TAPE_CELLS];
	logic [15:0] head;
	bit stopped;

	outcome_t pending[$];
	row_t rows[$];
	int mismatches = 0;
	int accepted = 0;
	bit calm = 1'b0;

	tape_machine_executor #(.TAPE_CELLS(TAPE_CELLS), .CELL_BITS(8)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .pointer_move(pointer_move), .value_a(value_a),
		.offset_b(offset_b), .value_b(value_b), .offset_c(offset_c),
		.value_c(value_c), .input_byte(input_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.branch_taken(branch_taken), .print_valid(print_valid),
		.print_byte(print_byte), .halted(halted), .walk_overflow(walk_overflow)
	);

	always #5 clk = ~clk;

	// Runs one of the three walks on an overlay of the tape. With commit set the
	// overlay and the final pointer are written back; otherwise it is only a trial
	// that tells how many steps the walk would take, capped at cap.
	function automatic int run_walk(op_t op, logic [15:0] ob, logic [7:0] inc,
			logic [15:0] oc, int cap, bit commit, output bit ovf);
		logic [7:0] ovl [int];
		logic [15:0] p, t;
		logic [7:0] v;
		int n;
		p = head;
		n = 0;
		v = ovl.exists(int'(p)) ? ovl[int'(p)] : tape_mem[p];
		while (v != 0 && n < cap) begin
			case (op)
				OP_ADDWZ: begin
					t = p + ob;
					ovl[int'(t)] = (ovl.exists(int'(t)) ? ovl[int'(t)] : tape_mem[t]) + inc;
					p = p + oc;
				end
				OP_ZFIND: p = p + ob;
				default: begin
					// The minus-find carries one unit from cell to cell.
					ovl[int'(p)] = v - 8'd1;
					p = p + ob;
					ovl[int'(p)] = (ovl.exists(int'(p)) ? ovl[int'(p)] : tape_mem[p]) + 8'd1;
				end
			endcase
			n++;
			v = ovl.exists(int'(p)) ? ovl[int'(p)] : tape_mem[p];
		end
		ovf = (v != 0);
		if (commit) begin
			foreach (ovl[k])
				tape_mem[k] = ovl[k];
			head = p;
		end
		return n;
	endfunction

	// Executes one accepted word on the shadow machine and returns its result.
	function automatic outcome_t exec_word(word_t w);
		outcome_t r;
		logic [15:0] ib_addr, ic_addr;
		logic [7:0] c, s1, s2;
		int n;
		r = '{default: '0};
		if (!stopped) begin
			head = head + w.mv;
			ib_addr = head + w.ob;
			ic_addr = head + w.oc;
			c = tape_mem[head];
			s1 = tape_mem[ib_addr];
			s2 = tape_mem[ic_addr];
			case (w.op)
				OP_ADD: tape_mem[head] = c + w.va[7:0];
				OP_SET: tape_mem[head] = w.va[7:0];
				OP_LEND: r.taken = (c != 0);
				OP_LSTART: r.taken = (c == 0);
				OP_ADDWZ, OP_ZFIND, OP_MFIND:
					n = run_walk(w.op, w.ob, w.vb[7:0], w.oc, TAPE_CELLS, 1'b1, r.ovf);
				OP_CALC: tape_mem[head] = w.va[7:0] + s1 * w.vb[7:0] + s2 * w.vc[7:0];
				OP_CALC2: tape_mem[head] = w.va[7:0] + s1 * w.vb[7:0];
				OP_CALC3: tape_mem[head] = c + s1 * w.vb[7:0];
				OP_COPY: tape_mem[head] = s1;
				OP_ACCUM: tape_mem[head] = c + s1;
				OP_INPUT: tape_mem[head] = w.ib;
				OP_PRINT: begin
					r.pv = 1'b1;
					r.pb = (w.va == -16'sd1) ? c : w.va[7:0];
				end
				OP_STOP: stopped = 1'b1;
				default: ;
			endcase
		end
		r.halt = stopped;
		return r;
	endfunction

	function automatic logic [15:0] rnd16();
		if ($urandom_range(99) < 75)
			return 16'($signed($urandom_range(8)) - 4);
		return 16'($urandom());
	endfunction

	// Random word; a walk that would run long is swapped for a nop, so that
	// the long walks stay confined to the directed part.
	function automatic word_t random_word();
		word_t w;
		bit ovf;
		w.op = op_t'($urandom_range(14));
		w.mv = rnd16();
		w.va = ($urandom_range(9) == 0) ? -16'sd1 : rnd16();
		w.ob = rnd16();
		w.vb = rnd16();
		w.oc = rnd16();
		w.vc = rnd16();
		w.ib = 8'($urandom());
		if ($urandom_range(9) == 0)
			w.va = 16'($urandom());
		if (w.op inside {OP_ADDWZ, OP_ZFIND, OP_MFIND}) begin
			head = head + w.mv;
			if (run_walk(w.op, w.ob, w.vb[7:0], w.oc, WALK_CAP, 1'b0, ovf) >= WALK_CAP)
				w.op = OP_NOP;
			head = head - w.mv;
		end
		return w;
	endfunction

	function automatic word_t mk(op_t op, logic signed [15:0] mv = 0,
			logic signed [15:0] va = 0, logic signed [15:0] ob = 0,
			logic signed [15:0] vb = 0, logic signed [15:0] oc = 0,
			logic signed [15:0] vc = 0, logic [7:0] ib = 0);
		word_t w;
		w = '{op, mv, va, ob, vb, oc, vc, ib};
		return w;
	endfunction

	function automatic outcome_t res(bit taken, bit pv, logic [7:0] pb, bit halt, bit ovf);
		outcome_t r;
		r = '{taken, pv, pb, halt, ovf};
		return r;
	endfunction

	// Offers one word, holds it until taken, and files its expected result.
	// The typed result of a directed row replaces the predicted one.
	task automatic send_word(word_t w, bit typed = 0, outcome_t want = '{default: '0});
		outcome_t r;
		while (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= w.op;
		pointer_move <= w.mv;
		value_a <= w.va;
		offset_b <= w.ob;
		value_b <= w.vb;
		offset_c <= w.oc;
		value_c <= w.vc;
		input_byte <= w.ib;
		do
			@(posedge clk);
		while (in_stall);
		r = exec_word(w);
		pending.push_back(typed ? want : r);
		accepted++;
	endtask

	// Result checker: every taken word is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word at %0t", $realtime);
			end else begin
				outcome_t e;
				e = pending.pop_front();
				if (branch_taken !== e.taken || print_valid !== e.pv || print_byte !== e.pb ||
						halted !== e.halt || walk_overflow !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: exp t%0b p%0b %h h%0b o%0b got t%0b p%0b %h h%0b o%0b",
							$realtime, e.taken, e.pv, e.pb, e.halt, e.ovf, branch_taken,
							print_valid, print_byte, halted, walk_overflow);
				end
			end
		end
	end

	// Receiver: random stalls, a calm stretch, and one long hold-off that lets
	// the block fill up and stall its input while words keep being offered.
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && accepted >= 300) begin
				held = 1'b1;
				repeat (300) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= !calm && ($urandom_range(99) < 21);
		end
	end

	initial begin
		#100000000;
		$display("[tape_machine_executor] ERROR");
		$finish;
	end

	initial begin
		int waited;
		foreach (tape_mem[k])
			tape_mem[k] = '0;
		head = '0;
		stopped = 1'b0;

		// Directed rows; the typed results follow from a tape that is all zero.
		rows.push_back('{mk(OP_LSTART), 1, res(1, 0, 8'h00, 0, 0)});
		rows.push_back('{mk(OP_LEND), 1, res(0, 0, 8'h00, 0, 0)});
		rows.push_back('{mk(OP_SET, 0, -1), 1, res(0, 0, 8'h00, 0, 0)});
		rows.push_back('{mk(OP_PRINT, 0, -1), 1, res(0, 1, 8'hFF, 0, 0)});
		rows.push_back('{mk(OP_ADD, 0, 1), 1, res(0, 0, 8'h00, 0, 0)});
		rows.push_back('{mk(OP_LSTART), 1, res(1, 0, 8'h00, 0, 0)});
		rows.push_back('{mk(OP_PRINT, 0, 16'sh1234), 1, res(0, 1, 8'h34, 0, 0)});
		rows.push_back('{mk(OP_SET, 32767, 16'sh7FFF), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_INPUT, -32768, 0, 0, 0, 0, 0, 8'hA5), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_PRINT, 0, -1), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_CALC, 1, 5, -1, 3, 32767, -32768), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_CALC2, 0, 7, 1, -1), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_CALC3, 0, 0, -32768, 2), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_COPY, 0, 0, -1), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_ACCUM, 0, 0, 2), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_SET, 100, 3), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_ADDWZ, 0, 0, 5, 2, 1), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_SET, 1, -1), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_SET, -1, 1), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_MFIND, 0, 0, 1), 0, res(0, 0, 0, 0, 0)});
		rows.push_back('{mk(OP_ZFIND, 50, 0, -1), 0, res(0, 0, 0, 0, 0)});
		// A walk with zero stride over a nonzero cell never ends and is cut off.
		rows.push_back('{mk(OP_SET, 200, 1), 1, res(0, 0, 8'h00, 0, 0)});
		rows.push_back('{mk(OP_ZFIND, 0, 0, 0), 1, res(0, 0, 8'h00, 0, 1)});
		rows.push_back('{mk(OP_NOP, -1, -1, -1, -1, -1, -1, 8'hFF), 0, res(0, 0, 0, 0, 0)});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_word(rows[i].w, rows[i].typed, rows[i].r);
		for (int i = 0; i < RAND_WORDS; i++) begin
			calm = (i >= 500 && i < 650);
			send_word(random_word());
		end
		calm = 1'b0;
		// After stop every word only reports the halt.
		send_word(mk(OP_STOP, 3), 1, res(0, 0, 8'h00, 1, 0));
		send_word(mk(OP_PRINT, 0, -1), 1, res(0, 0, 8'h00, 1, 0));
		send_word(mk(OP_LSTART, 7), 1, res(0, 0, 8'h00, 1, 0));
		in_valid <= 1'b0;

		waited = 0;
		while (pending.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending.size() == 0)
			$display("[tape_machine_executor] OK");
		else
			$display("[tape_machine_executor] ERROR");
		$finish;
	end
endmodule

// File: files.f
design/tme_pkg.sv
design/tme_ram.sv
design/tape_machine_executor.sv
tb/sv/tb_tape_machine_executor.sv
